// ===== rtl/hermite_basis_eval_core_defines.svh =====
// ---------------------------------------------------------------------------
// Hermite basis evaluator: assertion macros
// Shared property wrappers for the checks at the end of the RTL modules.
// ---------------------------------------------------------------------------
`ifndef HERMITE_BASIS_EVAL_CORE_DEFINES_SVH
`define HERMITE_BASIS_EVAL_CORE_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define HBE_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define HBE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hbe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbe_pkg
// Widths, coefficient tables and the word that travels down the cell chain.
// ---------------------------------------------------------------------------
package hbe_pkg;

   localparam int IDX_W     = 3;
   localparam int DERIV_W   = 3;
   localparam int POINT_W   = 20;
   localparam int VALUE_W   = 48;
   localparam int ORDER_W   = 2;
   localparam int NUM_CELLS = 6;
   localparam int HC_W      = 6;
   localparam int FF_W      = 8;
   localparam int COEF_W    = HC_W + FF_W + 1;

   localparam int HALF_W     = VALUE_W / 2;
   localparam int LO_PROD_W  = HALF_W + 1 + POINT_W;
   localparam int HI_PROD_W  = HALF_W + POINT_W;
   localparam int PROD_W     = VALUE_W + POINT_W;
   localparam int SUM_W      = PROD_W + 1;

   localparam logic [ORDER_W-1:0] ORDER_LINEAR  = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_CUBIC   = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_QUINTIC = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_RESET   = ORDER_CUBIC;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 48'sh8000_0000_0000;

   // Twice the monomial coefficients, ascending powers, per order and index.
   localparam logic signed [HC_W-1:0] HALF_COEF [3][8][NUM_CELLS] = '{
      '{ '{2, -2, 0, 0, 0, 0}, '{0, 2, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0} },
      '{ '{2, 0, -6, 4, 0, 0}, '{0, 2, -4, 2, 0, 0},
         '{0, 0, 6, -4, 0, 0}, '{0, 0, -2, 2, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0} },
      '{ '{2, 0, 0, -20, 30, -12}, '{0, 2, 0, -12, 16, -6},
         '{0, 0, 1, -3, 3, -1},    '{0, 0, 0, 20, -30, 12},
         '{0, 0, 0, -8, 14, -6},   '{0, 0, 0, 1, -2, 1},
         '{0, 0, 0, 0, 0, 0},      '{0, 0, 0, 0, 0, 0} }
   };

   // Falling factorial k!/(k-d)!, zero where d exceeds k.
   localparam logic [FF_W-1:0] FALL_FACT [NUM_CELLS][8] = '{
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0, 0, 0},
      '{1, 2, 2, 0, 0, 0, 0, 0},
      '{1, 3, 6, 6, 0, 0, 0, 0},
      '{1, 4, 12, 24, 24, 0, 0, 0},
      '{1, 5, 20, 60, 120, 120, 0, 0}
   };

   typedef struct packed {
      logic [DERIV_W-1:0]                  deriv;
      logic signed [POINT_W-1:0]           point;
      logic                                status;
      logic [NUM_CELLS-1:0][COEF_W-1:0]    coef;
      logic signed [VALUE_W-1:0]           acc;
   } cell_word_type;

endpackage

// ===== rtl/hbe_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbe_cell
// One Horner step: acc = sat(floor(acc * t / 2^F) + c_k), two stages deep.
// ---------------------------------------------------------------------------
module hbe_cell
   import hbe_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int POWER     = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  cell_word_type in_word,
   output logic          out_valid,
   output cell_word_type out_word
);

   logic                          a_valid_ff;
   cell_word_type                 a_word_ff;
   logic signed [LO_PROD_W-1:0]   a_lo_ff;
   logic signed [HI_PROD_W-1:0]   a_hi_ff;
   logic signed [LO_PROD_W-1:0]   lo_prod;
   logic signed [HI_PROD_W-1:0]   hi_prod;

   logic                          b_valid_ff;
   cell_word_type                 b_word_ff;
   cell_word_type                 b_word_in;

   logic [PROD_W-1:0]             prod;
   logic signed [PROD_W-1:0]      prod_shift;
   logic [COEF_W-1:0]             coef;
   logic [SUM_W-1:0]              coef_scaled;
   logic [SUM_W-1:0]              sum;
   logic [SUM_W-VALUE_W:0]        sum_top;
   logic                          active;

   // Split the 48-bit accumulator so each multiplier stays narrow.
   assign lo_prod = $signed({1'b0, in_word.acc[HALF_W-1:0]}) * in_word.point;
   assign hi_prod = $signed(in_word.acc[VALUE_W-1:HALF_W]) * in_word.point;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff <= in_word;
      a_lo_ff   <= lo_prod;
      a_hi_ff   <= hi_prod;
      b_word_ff <= b_word_in;
   end

   assign prod        = {a_hi_ff, {HALF_W{1'b0}}}
                      + {{(PROD_W - LO_PROD_W){a_lo_ff[LO_PROD_W-1]}}, a_lo_ff};
   assign prod_shift  = $signed(prod) >>> FRAC_BITS;
   assign coef        = a_word_ff.coef[POWER];
   assign coef_scaled = {{(SUM_W - COEF_W){coef[COEF_W-1]}}, coef} << (FRAC_BITS - 1);
   assign sum         = {prod_shift[PROD_W-1], prod_shift} + coef_scaled;
   assign sum_top     = sum[SUM_W-1:VALUE_W-1];
   // Powers below the derivative order drop out of the differentiated polynomial.
   assign active      = a_word_ff.deriv <= DERIV_W'(POWER);

   always_comb begin
      b_word_in = a_word_ff;
      if (active) begin
         if ((&sum_top) || (~|sum_top)) begin
            b_word_in.acc = sum[VALUE_W-1:0];
         end else if (sum[SUM_W-1]) begin
            b_word_in.acc = VALUE_MIN;
         end else begin
            b_word_in.acc = VALUE_MAX;
         end
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

// ===== rtl/hbe_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbe_decode
// Holds the order register, checks the index and builds scaled coefficients.
// ---------------------------------------------------------------------------
module hbe_decode
   import hbe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ORDER_W-1:0]        csr_wr_data,
   input  logic                      in_valid,
   input  logic [IDX_W-1:0]          in_dof_index,
   input  logic [DERIV_W-1:0]        in_deriv_order,
   input  logic signed [POINT_W-1:0] in_point,
   output logic                      out_valid,
   output cell_word_type             out_word
);

   logic [ORDER_W-1:0]      order_ff;
   logic [ORDER_W-1:0]      order;
   logic [IDX_W:0]          basis_count;
   logic                    bad_index;
   logic signed [HC_W-1:0]  half_coef [NUM_CELLS];
   logic signed [COEF_W-1:0] coef [NUM_CELLS];
   logic                    valid_ff;
   cell_word_type           word_ff;
   cell_word_type           word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         valid_ff <= in_valid;
      end
   end

   // The unused fourth code runs as quintic.
   assign order       = (order_ff > ORDER_QUINTIC) ? ORDER_QUINTIC : order_ff;
   assign basis_count = (IDX_W + 1)'({order, 1'b0}) + (IDX_W + 1)'(2);
   assign bad_index   = {1'b0, in_dof_index} >= basis_count;

   always_comb begin
      for (int k = 0; k < NUM_CELLS; k++) begin
         half_coef[k] = bad_index ? '0 : HALF_COEF[order][in_dof_index][k];
         coef[k]      = half_coef[k] * $signed({1'b0, FALL_FACT[k][in_deriv_order]});
      end
   end

   always_comb begin
      word_in.deriv  = in_deriv_order;
      word_in.point  = in_point;
      word_in.status = bad_index ? STATUS_BAD_INDEX : STATUS_OK;
      word_in.acc    = '0;
      for (int k = 0; k < NUM_CELLS; k++) begin
         word_in.coef[k] = coef[k];
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/hbe_out_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbe_out_fifo
// Result queue that absorbs every word still in the cell chain.
// ---------------------------------------------------------------------------
module hbe_out_fifo
   import hbe_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

`include "hermite_basis_eval_core_defines.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rd_fire;

   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign rd_fire  = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(wr_en) - CNT_W'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `HBE_ASSERT_IMPLIES(a_no_overflow, clock, reset, wr_en && (count_ff == CNT_W'(DEPTH)), rd_fire, "write into full result queue")
   `HBE_ASSERT_IMPLIES(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with pointers apart")
   `HBE_ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/hermite_basis_eval_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hermite_basis_eval_core
// Hermite basis polynomial (or derivative) evaluation by a chain of Horner cells.
// ---------------------------------------------------------------------------
//  channel | ports                                         | direction
//  req     | req_valid/ready, dof_index, deriv_order, point | in
//  rsp     | rsp_valid/ready, value, status                | out
//  csr     | csr_wr_en, csr_wr_data (continuity order)      | in
//
//  One word per cycle in and out while req_ready and rsp_ready are high; a
//  word passes the decode stage, six two-stage Horner cells and the result
//  queue before rsp_valid rises and the result handshake can come.
//  req_ready drops only while FIFO_DEPTH words are in flight or queued,
//  a limit that the queue depth alone sets.
//  Reset is synchronous; it sets the continuity order to cubic.
// ---------------------------------------------------------------------------
module hermite_basis_eval_core
   import hbe_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int FIFO_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ORDER_W-1:0]        csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [IDX_W-1:0]          req_dof_index,
   input  logic [DERIV_W-1:0]        req_deriv_order,
   input  logic signed [POINT_W-1:0] req_point,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_status
);

`include "hermite_basis_eval_core_defines.svh"

   localparam int IN_W = $clog2(FIFO_DEPTH + 1);

   logic            req_fire;
   logic            rsp_fire;
   logic [IN_W-1:0] inflight_ff;
   logic [IN_W-1:0] inflight_in;

   logic            chain_valid [NUM_CELLS+1];
   cell_word_type   chain_word  [NUM_CELLS+1];
   logic [VALUE_W:0] rsp_data;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   // Admit a word only while the queue can still hold it on arrival.
   assign req_ready = inflight_ff < IN_W'(FIFO_DEPTH);

   assign inflight_in = inflight_ff + IN_W'(req_fire) - IN_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   hbe_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .in_valid       (req_fire),
      .in_dof_index   (req_dof_index),
      .in_deriv_order (req_deriv_order),
      .in_point       (req_point),
      .out_valid      (chain_valid[0]),
      .out_word       (chain_word[0])
   );

   // Highest power first, as Horner's rule runs.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      hbe_cell #(
         .FRAC_BITS (FRAC_BITS),
         .POWER     (NUM_CELLS - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   hbe_out_fifo #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (VALUE_W + 1)
   ) u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (chain_valid[NUM_CELLS]),
      .wr_data  ({chain_word[NUM_CELLS].status, chain_word[NUM_CELLS].acc}),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (rsp_data)
   );

   assign rsp_status = rsp_data[VALUE_W];
   assign rsp_value  = $signed(rsp_data[VALUE_W-1:0]);

   `HBE_ASSERT_IMPLIES(a_bad_index_zero, clock, reset, rsp_valid && (rsp_status == STATUS_BAD_INDEX), rsp_value == '0, "bad index word carries a nonzero value")
   `HBE_ASSERT_HOLDS(a_inflight_range, clock, reset, inflight_ff <= IN_W'(FIFO_DEPTH), "words in flight beyond queue depth")
   `HBE_ASSERT_IMPLIES(a_rsp_has_credit, clock, reset, rsp_valid, inflight_ff != '0, "result shown with nothing in flight")

endmodule
